// ===== sv/ecv_pkg.sv =====
// Constants and the month-start table shared by the epoch to UTC civil converter.
package ecv_pkg;

    // Field widths of the result word
    localparam int unsigned YEAR_W   = 12;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned DAY_W    = 5;
    localparam int unsigned HOUR_W   = 5;
    localparam int unsigned MINUTE_W = 6;
    localparam int unsigned SECOND_W = 6;

    // 86400 = 128 * 675: the low seven bits of the epoch pass straight into the time of day
    localparam int unsigned DAY_SEC_SHIFT = 7;
    localparam logic [9:0]  DAY_SEC_ODD   = 10'd675;

    localparam logic [19:0] SHIFT_MARCH0  = 20'd719468;
    localparam logic [19:0] DAYS_CYCLE    = 20'd146097;
    localparam logic [17:0] DAYS_4Y       = 18'd1460;
    localparam logic [17:0] DAYS_100Y     = 18'd36524;
    localparam logic [17:0] DAYS_CYCLE_M1 = 18'd146096;
    localparam logic [17:0] DAYS_YEAR     = 18'd365;
    localparam logic [11:0] YEARS_CYCLE   = 12'd400;
    localparam logic [16:0] SECS_HOUR     = 17'd3600;
    localparam logic [11:0] SECS_MIN      = 12'd60;
    localparam logic [10:0] MONTH_SPAN    = 11'd153;

    // Day of the March-based year on which month index mp starts: (153 * mp + 2) / 5
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] ds;
        case (mp)
            4'd0:    ds = 9'd0;
            4'd1:    ds = 9'd31;
            4'd2:    ds = 9'd61;
            4'd3:    ds = 9'd92;
            4'd4:    ds = 9'd122;
            4'd5:    ds = 9'd153;
            4'd6:    ds = 9'd184;
            4'd7:    ds = 9'd214;
            4'd8:    ds = 9'd245;
            4'd9:    ds = 9'd275;
            4'd10:   ds = 9'd306;
            4'd11:   ds = 9'd337;
            default: ds = 9'd0;
        endcase
        return ds;
    endfunction

endpackage

// ===== sv/ecv_const_div.sv =====
// Pipelined division by a constant: registered reciprocal product, quotient by bit select.
module ecv_const_div #(
    parameter int unsigned XW  = 16,
    parameter int unsigned DIV = 3,
    parameter int unsigned QW  = 8
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [XW-1:0] i_x,
    output logic [QW-1:0] o_q
);

    // Rounded-up reciprocal with K = XW + clog2(DIV) is exact for every XW-bit dividend
    localparam int unsigned LG   = $clog2(DIV);
    localparam int unsigned K    = XW + LG;
    localparam int unsigned MW   = XW + 1;
    localparam int unsigned PW   = XW + MW;
    localparam logic [63:0] M64  = ((64'd1 << K) + 64'(DIV) - 64'd1) / 64'(DIV);
    localparam logic [MW-1:0] MULT = M64[MW-1:0];

    logic [PW-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= {{MW{1'b0}}, i_x} * {{XW{1'b0}}, MULT};
        end
    end

    assign o_q = r_prod[K +: QW];

endmodule

// ===== sv/epoch_to_utc_civil.sv =====
// Top level: pipelined conversion of 32-bit epoch seconds to UTC civil date and time.
//
// Usage
//   Input stream: one word per timestamp, i_s_axis_tdata[31:0] = seconds since
//   1970-01-01 00:00:00 UTC, unsigned. Output stream: one word per input word,
//   same order, carrying year, month, day, hour, minute and second (proleptic
//   Gregorian, no leap seconds).
//   Throughput: one word per cycle, sustained while i_m_axis_tready is high.
//   Each of the eight stages holds reciprocal multiplies side by side (by 675,
//   1460, 3600, 365, 60 or 153) and at most one constant multiply followed by
//   a subtract; that depth sets the clock.
//   Every stage carries its own valid bit and advances when it is empty or when
//   the stage after it advances, so bubbles collapse.
//   Stall: when i_m_axis_tready is low, the output word holds and the stages
//   behind it keep filling; o_s_axis_tready falls only once all eight stages
//   hold a word. Nothing is dropped or repeated.
//   Reset (i_rst_n low, synchronous): clear all valid bits; the datapath
//   registers are not reset. There is no configuration and no state that spans
//   words, so the block accepts a word as soon as reset is released.
module epoch_to_utc_civil (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] epoch_seconds
    // output stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata    // [11:0] year, [15:12] month, [20:16] day,
                                          // [25:21] hour, [31:26] minute,
                                          // [37:32] second, [39:38] zero
);

    localparam int unsigned NSTG = 8;

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_adv;

    // Stage advance: a stage loads when it is empty or its word moves on
    always_comb begin
        w_adv[NSTG-1] = !r_vld[NSTG-1] || i_m_axis_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    assign o_s_axis_tready = w_adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) begin
                r_vld[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Stage 0: days = (secs >> 7) / 675, product registered in the divider
    // ---------------------------------------------------------------------
    logic [15:0] w_days;
    logic [6:0]  r0_lo7;
    logic [9:0]  r0_s10;

    ecv_const_div #(.XW(25), .DIV(675), .QW(16)) u_div_day (
        .i_clk (i_clk),
        .i_en  (w_adv[0]),
        .i_x   (i_s_axis_tdata[31:ecv_pkg::DAY_SEC_SHIFT]),
        .o_q   (w_days)
    );

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r0_lo7 <= i_s_axis_tdata[ecv_pkg::DAY_SEC_SHIFT-1:0];
            r0_s10 <= i_s_axis_tdata[ecv_pkg::DAY_SEC_SHIFT +: 10];
        end
    end

    // ---------------------------------------------------------------------
    // Stage 1: time of day, shift day count to March-based era, split cycle
    // ---------------------------------------------------------------------
    logic [25:0] w_p675;
    logic [9:0]  w_rem;
    logic [19:0] w_z;
    logic [17:0] w_doc;
    logic [2:0]  w_cyc;
    logic [16:0] r1_tod;
    logic [17:0] r1_doc;
    logic [2:0]  r1_cyc;

    always_comb begin
        w_p675 = 26'(w_days) * 26'(ecv_pkg::DAY_SEC_ODD);
        // remainder is below 675, so ten low bits suffice
        w_rem  = r0_s10 - w_p675[9:0];
        w_z    = 20'(w_days) + ecv_pkg::SHIFT_MARCH0;
        // any 32-bit epoch lands in the fifth or sixth 400-year cycle
        if (w_z >= 20'(ecv_pkg::DAYS_CYCLE * 20'd5)) begin
            w_cyc = 3'd5;
            w_doc = 18'(w_z - 20'(ecv_pkg::DAYS_CYCLE * 20'd5));
        end else begin
            w_cyc = 3'd4;
            w_doc = 18'(w_z - 20'(ecv_pkg::DAYS_CYCLE * 20'd4));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r1_tod <= {w_rem, r0_lo7};
            r1_doc <= w_doc;
            r1_cyc <= w_cyc;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 2: doc / 1460 and tod / 3600 products; century corrections
    // ---------------------------------------------------------------------
    logic [6:0]  w_q1460;
    logic [4:0]  w_hour;
    logic [17:0] r2_doc;
    logic [2:0]  r2_cyc;
    logic [16:0] r2_tod;
    logic [2:0]  r2_cent;
    logic        r2_last;

    ecv_const_div #(.XW(18), .DIV(ecv_pkg::DAYS_4Y), .QW(7)) u_div_4y (
        .i_clk (i_clk),
        .i_en  (w_adv[2]),
        .i_x   (r1_doc),
        .o_q   (w_q1460)
    );

    ecv_const_div #(.XW(17), .DIV(3600), .QW(5)) u_div_hour (
        .i_clk (i_clk),
        .i_en  (w_adv[2]),
        .i_x   (r1_tod),
        .o_q   (w_hour)
    );

    always_ff @(posedge i_clk) begin
        if (w_adv[2]) begin
            r2_doc  <= r1_doc;
            r2_cyc  <= r1_cyc;
            r2_tod  <= r1_tod;
            // doc / 36524 for doc up to 146096
            r2_cent <= 3'(r1_doc >= ecv_pkg::DAYS_100Y)
                     + 3'(r1_doc >= 18'(ecv_pkg::DAYS_100Y * 18'd2))
                     + 3'(r1_doc >= 18'(ecv_pkg::DAYS_100Y * 18'd3))
                     + 3'(r1_doc >= 18'(ecv_pkg::DAYS_100Y * 18'd4));
            // last day of the cycle
            r2_last <= (r1_doc >= ecv_pkg::DAYS_CYCLE_M1);
        end
    end

    // ---------------------------------------------------------------------
    // Stage 3: day count with leap days removed, ready for / 365
    // ---------------------------------------------------------------------
    logic [17:0] r3_a;
    logic [17:0] r3_doc;
    logic [2:0]  r3_cyc;
    logic [4:0]  r3_hour;
    logic [16:0] r3_tod;

    always_ff @(posedge i_clk) begin
        if (w_adv[3]) begin
            r3_a    <= r2_doc - 18'(w_q1460) + 18'(r2_cent) - 18'(r2_last);
            r3_doc  <= r2_doc;
            r3_cyc  <= r2_cyc;
            r3_hour <= w_hour;
            r3_tod  <= r2_tod;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 4: / 365 product; seconds within the hour
    // ---------------------------------------------------------------------
    logic [8:0]  w_yoc;
    logic [16:0] w_hsec;
    logic [17:0] r4_doc;
    logic [2:0]  r4_cyc;
    logic [4:0]  r4_hour;
    logic [11:0] r4_mos;

    ecv_const_div #(.XW(18), .DIV(365), .QW(9)) u_div_year (
        .i_clk (i_clk),
        .i_en  (w_adv[4]),
        .i_x   (r3_a),
        .o_q   (w_yoc)
    );

    assign w_hsec = 17'(r3_hour) * ecv_pkg::SECS_HOUR;

    always_ff @(posedge i_clk) begin
        if (w_adv[4]) begin
            r4_doc  <= r3_doc;
            r4_cyc  <= r3_cyc;
            r4_hour <= r3_hour;
            r4_mos  <= 12'(r3_tod - w_hsec);
        end
    end

    // ---------------------------------------------------------------------
    // Stage 5: day of year and March-based year; / 60 product
    // ---------------------------------------------------------------------
    logic [5:0]  w_min;
    logic [1:0]  w_ycent;
    logic [17:0] w_ydays;
    logic [8:0]  r5_doy;
    logic [11:0] r5_yr;
    logic [4:0]  r5_hour;
    logic [11:0] r5_mos;

    ecv_const_div #(.XW(12), .DIV(60), .QW(6)) u_div_min (
        .i_clk (i_clk),
        .i_en  (w_adv[5]),
        .i_x   (r4_mos),
        .o_q   (w_min)
    );

    always_comb begin
        // yoc / 100 for yoc up to 399
        w_ycent = 2'(w_yoc >= 9'd100) + 2'(w_yoc >= 9'd200) + 2'(w_yoc >= 9'd300);
        w_ydays = 18'(w_yoc) * ecv_pkg::DAYS_YEAR + 18'(w_yoc[8:2]) - 18'(w_ycent);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[5]) begin
            r5_doy  <= 9'(r4_doc - w_ydays);
            r5_yr   <= 12'(w_yoc) + 12'(r4_cyc) * ecv_pkg::YEARS_CYCLE;
            r5_hour <= r4_hour;
            r5_mos  <= r4_mos;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 6: (5 * doy + 2) / 153 product; minute and second
    // ---------------------------------------------------------------------
    logic [10:0] w_mx;
    logic [3:0]  w_mp;
    logic [11:0] w_msec;
    logic [8:0]  r6_doy;
    logic [11:0] r6_yr;
    logic [4:0]  r6_hour;
    logic [5:0]  r6_min;
    logic [5:0]  r6_sec;

    assign w_mx   = {r5_doy, 2'b00} + 11'(r5_doy) + 11'd2;
    assign w_msec = 12'(w_min) * ecv_pkg::SECS_MIN;

    ecv_const_div #(.XW(11), .DIV(ecv_pkg::MONTH_SPAN), .QW(4)) u_div_month (
        .i_clk (i_clk),
        .i_en  (w_adv[6]),
        .i_x   (w_mx),
        .o_q   (w_mp)
    );

    always_ff @(posedge i_clk) begin
        if (w_adv[6]) begin
            r6_doy  <= r5_doy;
            r6_yr   <= r5_yr;
            r6_hour <= r5_hour;
            r6_min  <= w_min;
            r6_sec  <= 6'(r5_mos - w_msec);
        end
    end

    // ---------------------------------------------------------------------
    // Stage 7: day of month, civil month, January and February roll the year
    // ---------------------------------------------------------------------
    logic [8:0]  w_mstart;
    logic [3:0]  w_month;
    logic [11:0] r7_year;
    logic [3:0]  r7_month;
    logic [4:0]  r7_day;
    logic [4:0]  r7_hour;
    logic [5:0]  r7_min;
    logic [5:0]  r7_sec;

    always_comb begin
        w_mstart = ecv_pkg::month_start(w_mp);
        w_month  = (w_mp < 4'd10) ? (w_mp + 4'd3) : (w_mp - 4'd9);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[7]) begin
            r7_year  <= r6_yr + 12'(w_month <= 4'd2);
            r7_month <= w_month;
            r7_day   <= 5'(r6_doy - w_mstart + 9'd1);
            r7_hour  <= r6_hour;
            r7_min   <= r6_min;
            r7_sec   <= r6_sec;
        end
    end

    assign o_m_axis_tvalid = r_vld[NSTG-1];
    assign o_m_axis_tdata  = {2'b00, r7_sec, r7_min, r7_hour, r7_day, r7_month, r7_year};

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> r_vld[0])
        else $error("accepted word did not enter the first stage");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (&r_vld && !i_m_axis_tready))
        else $error("input stalled while a stage was free");

    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r7_month >= 4'd1 && r7_month <= 4'd12))
        else $error("month out of range");

    a_day_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r7_day >= 5'd1 && r7_day <= 5'd31))
        else $error("day out of range");

    a_year_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r7_year >= 12'd1970 && r7_year <= 12'd2106))
        else $error("year out of range");

    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r7_hour <= 5'd23 && r7_min <= 6'd59 && r7_sec <= 6'd59))
        else $error("time of day out of range");

endmodule
